// File: sv/stil_pkg.sv
// shared types, constants and helpers for the sorted top-k insertion list
package stil_pkg;

    localparam int LIST_DEPTH = 64;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int KEY_W      = 32;
    localparam int ID_W       = 24;
    localparam int LIM_W      = 7;
    localparam int POS_W      = 6;
    localparam int RIDX_W     = 6;
    localparam int CMD_W      = 2;
    localparam int FILL_W     = 7;

    localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(64);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [KEY_W-1:0]  dist_key;
        logic [ID_W-1:0]   point_id;
        logic [RIDX_W-1:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic              accepted;
        logic [POS_W-1:0]  position;
        logic [FILL_W-1:0] fill_after;
        logic [KEY_W-1:0]  worst_key;
        logic              read_valid;
        logic [KEY_W-1:0]  read_key;
        logic [ID_W-1:0]   read_id;
    } t_out_item;

    typedef struct packed {
        logic             insert_en;
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } t_cell_ctrl;

    function automatic logic [CNT_W-1:0] eff_limit(input logic [LIM_W-1:0] lim);
        logic [CNT_W-1:0] res;
        if (lim == '0) begin
            res = CNT_W'(1);
        end else if (int'(lim) > LIST_DEPTH) begin
            res = CNT_W'(LIST_DEPTH);
        end else begin
            res = CNT_W'(lim);
        end
        return res;
    endfunction

endpackage

// File: sv/sorted_topk_insert_list_unit.sv
// sorted top-k insertion list: row of compare-and-shift cells with result stage
// the transfer edge updates the cell row and the stage 1 registers; the edge at which
// stage 1 moves on selects the worst and read entries into the output register, which
// holds while the output stalls; a new command is taken only once stage 1 is empty
// reset: synchronous active-low, list empty, list_limit 64, entries left undefined
module sorted_topk_insert_list_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  stil_pkg::t_in_item           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output stil_pkg::t_out_item          o_out_data,
    input  logic                         i_cfg_we,
    input  logic [stil_pkg::LIM_W-1:0]   i_cfg_wdata
);
    import stil_pkg::*;

    logic [CNT_W-1:0]  r_count;
    logic [LIM_W-1:0]  r_limit;
    logic              r_s1_valid;
    logic [CMD_W-1:0]  r_s1_cmd;
    logic              r_s1_acc;
    logic [POS_W-1:0]  r_s1_pos;
    logic [RIDX_W-1:0] r_s1_ridx;
    logic              r_out_valid;
    t_out_item         r_out_data;

    logic [LIST_DEPTH-1:0] w_valid;
    logic [LIST_DEPTH:0]   w_valid_ext;
    logic [LIST_DEPTH-1:0] w_lt;
    logic [LIST_DEPTH:0]   w_lt_ext;
    logic [LIST_DEPTH-1:0] w_here;
    logic [LIST_DEPTH-1:0] w_last;
    logic [LIST_DEPTH-1:0] w_rsel;
    logic [KEY_W-1:0]      w_key [LIST_DEPTH];
    logic [ID_W-1:0]       w_id  [LIST_DEPTH];

    logic              w_in_fire;
    logic              w_is_insert;
    logic [CNT_W-1:0]  w_lim;
    logic              w_full;
    logic              w_reject;
    logic              w_ins_en;
    logic [IDX_W-1:0]  w_pos;
    logic              w_s1_move;
    logic [KEY_W-1:0]  w_worst;
    logic [KEY_W-1:0]  w_rkey;
    logic [ID_W-1:0]   w_rid;
    logic              w_rhit;
    t_cell_ctrl        w_ctrl;

    assign o_in_stall  = r_s1_valid;
    assign w_in_fire   = i_in_valid && !o_in_stall;
    assign w_is_insert = (i_in_data.cmd == CMD_INSERT);
    assign w_lim       = eff_limit(r_limit);
    assign w_full      = (r_count >= w_lim);
    assign w_reject    = w_full && (w_lt == w_valid);
    assign w_ins_en    = w_in_fire && w_is_insert && !w_reject;
    assign w_s1_move   = r_s1_valid && (!r_out_valid || !i_out_stall);

    assign w_ctrl.insert_en = w_ins_en;
    assign w_ctrl.key       = i_in_data.dist_key;
    assign w_ctrl.id        = i_in_data.point_id;

    assign w_lt_ext    = {w_lt, 1'b1};
    assign w_valid_ext = {1'b0, w_valid};

    genvar gi;
    generate
        for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
            assign w_valid[gi] = (int'(r_count) > gi);
            assign w_here[gi]  = w_lt_ext[gi] && !w_lt[gi];
            assign w_last[gi]  = w_valid[gi] && !w_valid_ext[gi+1];
            assign w_rsel[gi]  = w_valid[gi] && (int'(r_s1_ridx) == gi);

            if (gi == 0) begin : g_head
                stil_cell u_cell (
                    .i_clk      (i_clk),
                    .i_ctrl     (w_ctrl),
                    .i_valid    (w_valid[gi]),
                    .i_prev_lt  (1'b1),
                    .i_prev_key (i_in_data.dist_key),
                    .i_prev_id  (i_in_data.point_id),
                    .o_lt       (w_lt[gi]),
                    .o_key      (w_key[gi]),
                    .o_id       (w_id[gi])
                );
            end else begin : g_body
                stil_cell u_cell (
                    .i_clk      (i_clk),
                    .i_ctrl     (w_ctrl),
                    .i_valid    (w_valid[gi]),
                    .i_prev_lt  (w_lt[gi-1]),
                    .i_prev_key (w_key[gi-1]),
                    .i_prev_id  (w_id[gi-1]),
                    .o_lt       (w_lt[gi]),
                    .o_key      (w_key[gi]),
                    .o_id       (w_id[gi])
                );
            end
        end
    endgenerate

    always_comb begin
        w_pos = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (w_here[i]) begin
                w_pos = w_pos | IDX_W'(i);
            end
        end
    end

    always_comb begin
        w_worst = '0;
        w_rkey  = '0;
        w_rid   = '0;
        w_rhit  = 1'b0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (w_last[i]) begin
                w_worst = w_worst | w_key[i];
            end
            if (w_rsel[i]) begin
                w_rkey = w_rkey | w_key[i];
                w_rid  = w_rid | w_id[i];
                w_rhit = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_limit     <= LIM_RESET;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
                if (r_count > eff_limit(i_cfg_wdata)) begin
                    r_count <= eff_limit(i_cfg_wdata);
                end
            end else if (w_in_fire) begin
                case (i_in_data.cmd)
                    CMD_INSERT: begin
                        if (!w_reject && !w_full) begin
                            r_count <= CNT_W'(r_count + 1'b1);
                        end
                    end
                    CMD_CLEAR: begin
                        r_count <= '0;
                    end
                    default: begin
                    end
                endcase
            end

            if (w_in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end

            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_cmd  <= i_in_data.cmd;
            r_s1_acc  <= w_is_insert && !w_reject;
            r_s1_pos  <= (w_is_insert && !w_reject) ? POS_W'(w_pos) : '0;
            r_s1_ridx <= i_in_data.read_index;
        end
        if (w_s1_move) begin
            r_out_data.accepted   <= (r_s1_cmd == CMD_INSERT) && r_s1_acc;
            r_out_data.position   <= (r_s1_cmd == CMD_INSERT) ? r_s1_pos : '0;
            r_out_data.fill_after <= FILL_W'(r_count);
            r_out_data.worst_key  <= w_worst;
            r_out_data.read_valid <= (r_s1_cmd == CMD_READ) && w_rhit;
            r_out_data.read_key   <= ((r_s1_cmd == CMD_READ) && w_rhit) ? w_rkey : '0;
            r_out_data.read_id    <= ((r_s1_cmd == CMD_READ) && w_rhit) ? w_rid : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_count_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= w_lim)
        else $error("fill count above effective limit");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ins_en && !w_full) |=> (r_count == CNT_W'($past(r_count) + 1'b1)))
        else $error("fill count did not grow on insert into non-full list");

    a_one_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins_en |-> $onehot(w_here))
        else $error("insert slot not unique");

    a_pos_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.accepted) |->
            (FILL_W'(o_out_data.position) < o_out_data.fill_after))
        else $error("insert position beyond fill");

    a_read_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.read_valid) |->
            (o_out_data.read_key <= o_out_data.worst_key))
        else $error("read entry larger than worst entry");

endmodule

// File: sv/stil_cell.sv
// one list slot: compares its entry with the offered key and shifts or loads
module stil_cell (
    input  logic                        i_clk,
    input  stil_pkg::t_cell_ctrl        i_ctrl,
    input  logic                        i_valid,
    input  logic                        i_prev_lt,
    input  logic [stil_pkg::KEY_W-1:0]  i_prev_key,
    input  logic [stil_pkg::ID_W-1:0]   i_prev_id,
    output logic                        o_lt,
    output logic [stil_pkg::KEY_W-1:0]  o_key,
    output logic [stil_pkg::ID_W-1:0]   o_id
);
    import stil_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic [ID_W-1:0]  r_id;

    assign o_lt  = i_valid && (r_key < i_ctrl.key);
    assign o_key = r_key;
    assign o_id  = r_id;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.insert_en) begin
            if (!i_prev_lt) begin
                r_key <= i_prev_key;
                r_id  <= i_prev_id;
            end else if (!o_lt) begin
                r_key <= i_ctrl.key;
                r_id  <= i_ctrl.id;
            end
        end
    end

endmodule

// File: test/tb_top.sv
// self-checking testbench for the sorted top-k insertion list unit
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stil_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 110;
    localparam int NUM_PHASES  = 12;

    typedef struct {
        bit               is_cfg;
        logic [LIM_W-1:0] limit_val;
        t_in_item         item;
        bit               has_result;
        t_out_item        result;
    } t_plan_row;

    logic             i_clk;
    logic             i_rst_n   = 1'b0;
    logic             in_valid  = 1'b0;
    t_in_item         in_data   = '0;
    logic             in_stall;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out_item        out_data;
    logic             cfg_we    = 1'b0;
    logic [LIM_W-1:0] cfg_wdata = '0;

    logic [KEY_W-1:0] list_key [LIST_DEPTH];
    logic [ID_W-1:0]  list_id  [LIST_DEPTH];
    int unsigned      list_fill  = 0;
    logic [LIM_W-1:0] limit_reg  = LIM_RESET;

    t_out_item   pending_results[$];
    t_plan_row   directed_rows[$];
    int unsigned phase_limit[NUM_PHASES] = '{64, 1, 3, 8, 0, 127, 16, 2, 64, 33, 5, 100};
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned mismatch_cnt  = 0;
    int unsigned result_cnt    = 0;
    int unsigned cycle_cnt     = 0;
    int unsigned placed_cnt    = 0;
    int unsigned refused_cnt   = 0;
    int unsigned hit_read_cnt  = 0;
    int unsigned limit_writes  = 0;

    sorted_topk_insert_list_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned kept_limit();
        int unsigned lim;
        lim = limit_reg;
        if (lim < 1) lim = 1;
        if (lim > LIST_DEPTH) lim = LIST_DEPTH;
        return lim;
    endfunction

    function automatic logic [KEY_W-1:0] bound_key();
        return (list_fill == 0) ? '0 : list_key[list_fill - 1];
    endfunction

    // updates the tracked list for one command and returns its result
    function automatic t_out_item apply_cmd(t_in_item it);
        t_out_item   res;
        int unsigned lim;
        int unsigned pos;
        int unsigned last;
        bit          full;
        res  = '0;
        lim  = kept_limit();
        full = (list_fill >= lim);
        case (t_cmd'(it.cmd))
            CMD_INSERT: begin
                if (!(full && it.dist_key > bound_key())) begin
                    pos = 0;
                    while (pos < list_fill && list_key[pos] < it.dist_key) pos++;
                    last = full ? lim - 1 : list_fill;
                    while (last > pos) begin
                        list_key[last] = list_key[last - 1];
                        list_id[last]  = list_id[last - 1];
                        last--;
                    end
                    list_key[pos] = it.dist_key;
                    list_id[pos]  = it.point_id;
                    if (!full) list_fill++;
                    res.accepted = 1'b1;
                    res.position = POS_W'(pos);
                end
            end
            CMD_CLEAR: begin
                list_fill = 0;
            end
            CMD_READ: begin
                if (it.read_index < list_fill) begin
                    res.read_valid = 1'b1;
                    res.read_key   = list_key[it.read_index];
                    res.read_id    = list_id[it.read_index];
                end
            end
            default: begin
            end
        endcase
        res.fill_after = FILL_W'(list_fill);
        res.worst_key  = bound_key();
        return res;
    endfunction

    function automatic t_plan_row cmd_row(t_cmd c, logic [KEY_W-1:0] k, logic [ID_W-1:0] id,
                                          logic [RIDX_W-1:0] ri);
        t_plan_row r;
        r.is_cfg          = 1'b0;
        r.limit_val       = '0;
        r.item.cmd        = c;
        r.item.dist_key   = k;
        r.item.point_id   = id;
        r.item.read_index = ri;
        r.has_result      = 1'b0;
        r.result          = '0;
        return r;
    endfunction

    function automatic t_plan_row cfg_row(logic [LIM_W-1:0] v);
        t_plan_row r;
        r           = cmd_row(CMD_NOP, '0, '0, '0);
        r.is_cfg    = 1'b1;
        r.limit_val = v;
        return r;
    endfunction

    function automatic t_plan_row known(t_plan_row r, bit acc, int unsigned pos,
                                        int unsigned fill, logic [KEY_W-1:0] worst, bit rv,
                                        logic [KEY_W-1:0] rk, logic [ID_W-1:0] rid);
        r.has_result        = 1'b1;
        r.result.accepted   = acc;
        r.result.position   = POS_W'(pos);
        r.result.fill_after = FILL_W'(fill);
        r.result.worst_key  = worst;
        r.result.read_valid = rv;
        r.result.read_key   = rk;
        r.result.read_id    = rid;
        return r;
    endfunction

    function automatic void add_row(t_plan_row r);
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    // mostly inserts with clustered keys so ties, full lists and refusals are frequent
    function automatic t_in_item random_cmd();
        t_in_item    it;
        int unsigned pick;
        it.point_id   = ID_W'($urandom);
        it.read_index = RIDX_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 35) begin
            it.dist_key = $urandom_range(63);
        end else if (pick < 65) begin
            it.dist_key = {1'b0, 8'($urandom_range(134, 120)), 23'($urandom)};
        end else if (pick < 85) begin
            it.dist_key = $urandom;
        end else if (pick < 92) begin
            it.dist_key = bound_key();
        end else begin
            it.dist_key = ($urandom_range(1) != 0) ? '1 : '0;
        end
        pick = $urandom_range(99);
        if (pick < 74) begin
            it.cmd = CMD_INSERT;
        end else if (pick < 95) begin
            it.cmd = CMD_READ;
            if (list_fill > 0 && $urandom_range(3) != 0) begin
                it.read_index = RIDX_W'($urandom_range(list_fill - 1));
            end
        end else if (pick < 96) begin
            it.cmd = CMD_CLEAR;
        end else begin
            it.cmd = CMD_NOP;
        end
        return it;
    endfunction

    task automatic send_cmd(t_in_item it, bit has_result, t_out_item result);
        t_out_item res;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        res = apply_cmd(it);
        if (t_cmd'(it.cmd) == CMD_INSERT) begin
            if (res.accepted) placed_cnt++;
            else refused_cnt++;
        end
        if (res.read_valid) hit_read_cnt++;
        pending_results.insert(pending_results.size(), has_result ? result : res);
    endtask

    task automatic write_limit(logic [LIM_W-1:0] v);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        limit_reg = v;
        if (list_fill > kept_limit()) list_fill = kept_limit();
        limit_writes++;
    endtask

    function automatic void check_result(t_out_item got);
        t_out_item want;
        result_cnt++;
        if (pending_results.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) $display("unexpected result transfer: %h", got);
        end else begin
            want = pending_results.pop_front();
            if (got.accepted !== want.accepted || got.position !== want.position ||
                got.fill_after !== want.fill_after || got.worst_key !== want.worst_key ||
                got.read_valid !== want.read_valid || got.read_key !== want.read_key ||
                got.read_id !== want.read_id) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) begin
                    $write("result %0d exp/got: acc %0d/%0d pos %0d/%0d fill %0d/%0d ",
                           result_cnt, want.accepted, got.accepted, want.position,
                           got.position, want.fill_after, got.fill_after);
                    $display("worst %h/%h rvalid %0d/%0d rkey %h/%h rid %h/%h",
                             want.worst_key, got.worst_key, want.read_valid,
                             got.read_valid, want.read_key, got.read_key, want.read_id,
                             got.read_id);
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) check_result(out_data);
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                 pending_results.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int phase;
        add_row(known(cmd_row(CMD_READ, '0, '0, '0),
                      0, 0, 0, '0, 0, '0, '0));
        add_row(known(cmd_row(CMD_NOP, '1, '1, '1),
                      0, 0, 0, '0, 0, '0, '0));
        add_row(known(cmd_row(CMD_INSERT, '1, '1, '0),
                      1, 0, 1, '1, 0, '0, '0));
        add_row(known(cmd_row(CMD_INSERT, '0, '0, '1),
                      1, 0, 2, '1, 0, '0, '0));
        add_row(known(cmd_row(CMD_READ, '0, '0, 6'd0),
                      0, 0, 2, '1, 1, '0, '0));
        add_row(known(cmd_row(CMD_READ, '0, '0, 6'd1),
                      0, 0, 2, '1, 1, '1, '1));
        add_row(known(cmd_row(CMD_READ, '0, '0, 6'd63),
                      0, 0, 2, '1, 0, '0, '0));
        add_row(cmd_row(CMD_INSERT, 32'h3F80_0000, 24'h000123, '0));
        add_row(cmd_row(CMD_INSERT, 32'h3F80_0000, 24'h000456, '0));
        add_row(cmd_row(CMD_READ, '0, '0, 6'd2));
        add_row(known(cmd_row(CMD_CLEAR, '0, '0, '0),
                      0, 0, 0, '0, 0, '0, '0));
        // limit of zero keeps a single entry
        add_row(cfg_row(7'd0));
        add_row(known(cmd_row(CMD_INSERT, 32'd100, 24'd1, '0),
                      1, 0, 1, 32'd100, 0, '0, '0));
        add_row(known(cmd_row(CMD_INSERT, 32'd101, 24'd2, '0),
                      0, 0, 1, 32'd100, 0, '0, '0));
        add_row(known(cmd_row(CMD_INSERT, 32'd100, 24'd3, '0),
                      1, 0, 1, 32'd100, 0, '0, '0));
        add_row(known(cmd_row(CMD_READ, '0, '0, 6'd0),
                      0, 0, 1, 32'd100, 1, 32'd100, 24'd3));
        add_row(cfg_row(7'd127));
        add_row(cmd_row(CMD_INSERT, 32'd50, 24'd4, '0));
        add_row(cmd_row(CMD_INSERT, 32'd70, 24'd5, '0));
        add_row(cmd_row(CMD_INSERT, 32'd60, 24'd6, '0));
        // lowering the limit drops the worst entries
        add_row(cfg_row(7'd2));
        add_row(cmd_row(CMD_READ, '0, '0, 6'd2));
        add_row(cmd_row(CMD_READ, '0, '0, 6'd1));
        add_row(cmd_row(CMD_INSERT, 32'd55, 24'd7, '0));
        add_row(cmd_row(CMD_INSERT, 32'd61, 24'd8, '0));
        add_row(cmd_row(CMD_INSERT, '0, '1, '1));
        add_row(cmd_row(CMD_READ, '0, '0, 6'd0));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                write_limit(directed_rows[i].limit_val);
            end else begin
                send_cmd(directed_rows[i].item, directed_rows[i].has_result,
                         directed_rows[i].result);
            end
        end

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            write_limit(LIM_W'(phase_limit[phase]));
            case (phase % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 84;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 84;
                end
                default: begin
                    send_idle_pct = 9;
                    stall_pct     = 9;
                end
            endcase
            repeat (PHASE_ITEMS) send_cmd(random_cmd(), 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("checked %0d results in %0d cycles over %0d limit writes",
                 result_cnt, cycle_cnt, limit_writes);
        $display("inserts placed %0d, refused %0d, reads that hit a stored entry %0d",
                 placed_cnt, refused_cnt, hit_read_cnt);
        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatching results", mismatch_cnt);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
